// ===== rtl/core/bcc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcc_pkg: CAN FD bit timing calculator package
// Shared types and constants for the bit timing divider chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int unsigned OscW   = 27;
  localparam int unsigned NRateW = 20;
  localparam int unsigned DRateW = 23;
  localparam int unsigned DenW   = 32;
  localparam int unsigned QuoW   = 10;
  localparam int unsigned CmpW   = 41;
  localparam int unsigned KW     = 4;

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 72;

  // Number of cells in the prescaler and quanta divisions.
  localparam int unsigned PreCells = 10;
  localparam int unsigned TqCells  = 6;

  localparam int unsigned NomTqTarget  = 20;
  localparam int unsigned DataTqTarget = 10;
  localparam int unsigned DataRateMult = 4;
  localparam int unsigned BrpMaxQ      = 256;
  localparam int unsigned NomTqMin     = 8;
  localparam int unsigned NomTqMax     = 40;
  localparam int unsigned DataTqMin    = 5;
  localparam int unsigned DataTqMax    = 25;

  // One restoring division in flight.
  typedef struct packed {
    logic [OscW-1:0] rem;
    logic [DenW-1:0] den;
    logic [QuoW-1:0] quo;
  } bcc_lane_t;

  // Everything one transaction carries down the chain.
  typedef struct packed {
    logic [OscW-1:0]   osc;
    logic [NRateW-1:0] nrate;
    logic [DRateW-1:0] drate;
    logic [7:0]        nbrp;
    logic [7:0]        dbrp;
    logic              nerr;
    logic              derr;
    bcc_lane_t         nl;
    bcc_lane_t         dl;
  } bcc_ctx_t;

endpackage

`default_nettype wire

// ===== rtl/core/bcc_cell.sv =====
// ----------------------------------------------------------------------------
// bcc_cell: one restoring division step
// Resolves quotient bit k_i of the nominal and data divisions and passes the
// transaction to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cell (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   en_i,
  input  wire logic [bcc_pkg::KW-1:0] k_i,
  input  wire logic                   valid_i,
  input  wire bcc_pkg::bcc_ctx_t      ctx_i,
  output logic                        valid_o,
  output bcc_pkg::bcc_ctx_t           ctx_o
);
  import bcc_pkg::*;

  logic              valid_q;
  bcc_ctx_t          ctx_q;
  bcc_ctx_t          ctx_d;
  logic [CmpW-1:0]   nsh;
  logic [CmpW-1:0]   dsh;

  // Trial subtraction of the shifted divisor in both lanes.
  always_comb begin
    ctx_d = ctx_i;
    nsh   = CmpW'(ctx_i.nl.den) << k_i;
    dsh   = CmpW'(ctx_i.dl.den) << k_i;
    if (CmpW'(ctx_i.nl.rem) >= nsh) begin
      ctx_d.nl.rem      = ctx_i.nl.rem - nsh[OscW-1:0];
      ctx_d.nl.quo[k_i] = 1'b1;
    end
    if (CmpW'(ctx_i.dl.rem) >= dsh) begin
      ctx_d.dl.rem      = ctx_i.dl.rem - dsh[OscW-1:0];
      ctx_d.dl.quo[k_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctx_q <= ctx_d;
    end
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;

endmodule

`default_nettype wire

// ===== rtl/core/can_fd_bit_timing_calc_top.sv =====
// ----------------------------------------------------------------------------
// can_fd_bit_timing_calc_top: CAN FD bit timing calculator
// Computes nominal and data phase prescaler, segments and SJW per request.
// ----------------------------------------------------------------------------
// A request can enter every cycle unless the output stalls; its result passes
// through the input register, the chain of division cells (ten for the
// prescaler), the multiply register, six more cells for the quanta count and
// the output register. The whole chain holds while a result waits on the
// output and m_axis_tready_i is low.
`default_nettype none

module can_fd_bit_timing_calc_top (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // osc_hz[26:0], nominal_rate[46:27], data_phase_rate[69:47]
  input  wire logic [bcc_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // nominal_ok[0], nominal_word[32:1], data_ok[33], data_word[65:34]
  output logic [bcc_pkg::OutDataW-1:0]       m_axis_tdata_o
);
  import bcc_pkg::*;

  logic              en;
  logic              prep_valid_q;
  bcc_ctx_t          prep_ctx_q;
  bcc_ctx_t          prep_ctx_d;
  logic [DRateW-1:0] drate_sel;

  logic              pv [PreCells+1];
  bcc_ctx_t          pc [PreCells+1];
  logic              mid_valid_q;
  bcc_ctx_t          mid_ctx_q;
  bcc_ctx_t          mid_ctx_d;
  logic              tv [TqCells+1];
  bcc_ctx_t          tc [TqCells+1];

  logic              out_valid_q;
  logic [65:0]       out_q;
  logic [65:0]       out_d;

  // The chain advances unless a finished result is being held.
  assign en = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = en;

  // Input stage: divisors for both prescaler divisions.
  always_comb begin
    prep_ctx_d       = '0;
    prep_ctx_d.osc   = s_axis_tdata_i[26:0];
    prep_ctx_d.nrate = s_axis_tdata_i[46:27];
    drate_sel        = (s_axis_tdata_i[69:47] != '0) ? s_axis_tdata_i[69:47]
                     : DRateW'(s_axis_tdata_i[46:27] * DataRateMult);
    prep_ctx_d.drate = drate_sel;
    prep_ctx_d.nl.rem = s_axis_tdata_i[26:0];
    prep_ctx_d.nl.den = DenW'(s_axis_tdata_i[46:27] * NomTqTarget);
    prep_ctx_d.dl.rem = s_axis_tdata_i[26:0];
    prep_ctx_d.dl.den = DenW'(drate_sel * DataTqTarget);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_ctx_q <= prep_ctx_d;
    end
  end

  // Prescaler division: quotient bits 9 down to 0, bit 9 flags overflow.
  assign pv[0] = prep_valid_q;
  assign pc[0] = prep_ctx_q;

  for (genvar i = 0; i < PreCells; i++) begin : g_pre
    bcc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .k_i    (KW'(PreCells - 1 - i)),
      .valid_i(pv[i]),
      .ctx_i  (pc[i]),
      .valid_o(pv[i+1]),
      .ctx_o  (pc[i+1])
    );
  end

  // Prescaler check and the divisor rate * prescaler for the quanta count.
  always_comb begin
    mid_ctx_d      = pc[PreCells];
    mid_ctx_d.nerr = pc[PreCells].nl.quo[9] || (pc[PreCells].nl.quo == '0)
                   || (pc[PreCells].nl.quo > QuoW'(BrpMaxQ));
    mid_ctx_d.derr = pc[PreCells].dl.quo[9] || (pc[PreCells].dl.quo == '0)
                   || (pc[PreCells].dl.quo > QuoW'(BrpMaxQ));
    mid_ctx_d.nbrp = 8'(pc[PreCells].nl.quo - 1'b1);
    mid_ctx_d.dbrp = 8'(pc[PreCells].dl.quo - 1'b1);
    mid_ctx_d.nl.rem = pc[PreCells].osc;
    mid_ctx_d.nl.den = DenW'(pc[PreCells].nrate) * DenW'(pc[PreCells].nl.quo[8:0]);
    mid_ctx_d.nl.quo = '0;
    mid_ctx_d.dl.rem = pc[PreCells].osc;
    mid_ctx_d.dl.den = DenW'(pc[PreCells].drate) * DenW'(pc[PreCells].dl.quo[8:0]);
    mid_ctx_d.dl.quo = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q <= 1'b0;
    end else if (en) begin
      mid_valid_q <= pv[PreCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mid_ctx_q <= mid_ctx_d;
    end
  end

  // Quanta division: quotient bits 5 down to 0.
  assign tv[0] = mid_valid_q;
  assign tc[0] = mid_ctx_q;

  for (genvar j = 0; j < TqCells; j++) begin : g_tq
    bcc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .k_i    (KW'(TqCells - 1 - j)),
      .valid_i(tv[j]),
      .ctx_i  (tc[j]),
      .valid_o(tv[j+1]),
      .ctx_o  (tc[j+1])
    );
  end

  // Output stage: range checks, sample point split and word packing.
  always_comb begin
    logic [5:0]  tq;
    logic [5:0]  dtq;
    logic [7:0]  q5;
    logic [7:0]  d5;
    logic [6:0]  t2m;
    logic [3:0]  d2m;
    logic        nok;
    logic        dok;
    logic [31:0] nword;
    logic [31:0] dword;
    tq  = tc[TqCells].nl.quo[5:0];
    dtq = tc[TqCells].dl.quo[5:0];
    // tq * 80 / 100 equals tq * 4 / 5; tq * 820 / 1024 is exact here.
    q5  = 8'((18'(tq) * 18'd820) >> 10);
    d5  = 8'((8'(dtq) * 8'd3) >> 2);
    t2m = 7'(8'(tq) - q5 - 8'd1);
    d2m = 4'(8'(dtq) - d5 - 8'd1);
    nok = !tc[TqCells].nerr && (tq >= 6'(NomTqMin)) && (tq <= 6'(NomTqMax));
    dok = nok && !tc[TqCells].derr && (dtq >= 6'(DataTqMin))
          && (dtq <= 6'(DataTqMax));
    nword = {tc[TqCells].nbrp, 8'(q5 - 8'd2), 1'b0, t2m, 1'b0, t2m};
    dword = {tc[TqCells].dbrp, 3'b0, 5'(d5 - 8'd2), 4'b0, d2m, 4'b0, d2m};
    if (!nok) begin
      nword = '0;
    end
    if (!dok) begin
      dword = '0;
    end
    out_d = {dword, dok, nword, nok};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= tv[TqCells];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q};

`ifndef SYNTH
  // Data timing is only reported together with valid nominal timing.
  a_data_needs_nom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q[33] || out_q[0]))
    else $error("data_ok without nominal_ok");

  // An invalid nominal result carries a zero word.
  a_nom_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q[0]) |-> (out_q[32:1] == '0))
    else $error("invalid nominal word not zero");

  // A held result stalls the input side.
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready_i) |-> !s_axis_tready_o)
    else $error("input accepted while output stalled");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: CAN FD bit timing calculator
// Drives timing requests through the stream input and compares every result
// against a behavioral predictor of the prescaler and segment computation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import bcc_pkg::*;

  typedef struct packed {
    logic [DRateW-1:0] drate;
    logic [NRateW-1:0] nrate;
    logic [OscW-1:0]   osc;
  } timing_req_t;

  typedef struct packed {
    logic [31:0] data_word;
    logic        data_ok;
    logic [31:0] nom_word;
    logic        nom_ok;
  } timing_res_t;

  localparam int unsigned PipeLatency = 19;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid_i;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i;
  logic [OutDataW-1:0] m_axis_tdata_o;

  timing_req_t pending_reqs[$];
  timing_res_t expected_timing[$];
  int          error_count = 0;
  int          send_idle_pct = 26;
  int          recv_idle_pct = 85;
  int          hold_off_cycles = 0;
  bit          send_pause = 0;
  bit          in_taken = 0;

  can_fd_bit_timing_calc_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Finds prescaler and quanta; returns 0 when no prescaler fits.
  function automatic bit find_prescaler(input longint unsigned osc, input longint unsigned rate,
                                        input longint unsigned target,
                                        output longint unsigned brp,
                                        output longint unsigned tq);
    longint unsigned den;
    longint unsigned q;
    brp = 0;
    tq = 0;
    den = rate * target;
    if (den == 0) return 0;
    q = osc / den;
    if (q == 0 || q - 1 > 255) return 0;
    brp = q - 1;
    tq = osc / (rate * q);
    return 1;
  endfunction

  function automatic timing_res_t compute_timing(input timing_req_t req);
    timing_res_t     res;
    longint unsigned brp, tq, dbrp, dtq, t1, t2, d1, d2, drate;
    res = '0;
    if (find_prescaler(req.osc, req.nrate, NomTqTarget, brp, tq) &&
        tq >= NomTqMin && tq <= NomTqMax) begin
      t1 = tq * 80 / 100 - 1;
      t2 = tq - t1 - 1;
      res.nom_ok = 1'b1;
      res.nom_word = {brp[7:0], 8'(t1 - 1), 1'b0, 7'(t2 - 1), 1'b0, 7'(t2 - 1)};
      drate = (req.drate != 0) ? longint'(req.drate) : longint'(req.nrate) * DataRateMult;
      if (find_prescaler(req.osc, drate, DataTqTarget, dbrp, dtq) &&
          dtq >= DataTqMin && dtq <= DataTqMax) begin
        d1 = dtq * 75 / 100 - 1;
        d2 = dtq - d1 - 1;
        res.data_ok = 1'b1;
        res.data_word = {dbrp[7:0], 3'b0, 5'(d1 - 1), 4'b0, 4'(d2 - 1), 4'b0, 4'(d2 - 1)};
      end
    end
    return res;
  endfunction

  // Input monitor: predicts the result of each accepted request transaction.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid_i && s_axis_tready_o) begin
      expected_timing.push_back(compute_timing(timing_req_t'(s_axis_tdata_i[69:0])));
    end
    in_taken <= rst_ni && s_axis_tvalid_i && s_axis_tready_o;
  end

  // Driver: offers queued requests at the falling edge.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (!s_axis_tvalid_i || in_taken) begin
        if (pending_reqs.size() > 0 && !send_pause &&
            $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i <= {2'b0, pending_reqs.pop_front()};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver backpressure, with an optional long hold-off.
  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      m_axis_tready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i) begin
    timing_res_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = timing_res_t'(m_axis_tdata_o[65:0]);
      if (expected_timing.size() == 0) begin
        $error("unexpected result transaction %h", got);
        error_count++;
      end else begin
        want = expected_timing.pop_front();
        if (got.nom_ok !== want.nom_ok) begin
          $error("nominal_ok expected %0d actual %0d", want.nom_ok, got.nom_ok);
          error_count++;
        end
        if (got.nom_word !== want.nom_word) begin
          $error("nominal_word expected %h actual %h", want.nom_word, got.nom_word);
          error_count++;
        end
        if (got.data_ok !== want.data_ok) begin
          $error("data_ok expected %0d actual %0d", want.data_ok, got.data_ok);
          error_count++;
        end
        if (got.data_word !== want.data_word) begin
          $error("data_word expected %h actual %h", want.data_word, got.data_word);
          error_count++;
        end
      end
    end
  end

  function automatic timing_req_t make_req(input int unsigned osc, input int unsigned nr,
                                           input int unsigned dr);
    timing_req_t req;
    req.osc = osc[26:0];
    req.nrate = nr[19:0];
    req.drate = dr[22:0];
    return req;
  endfunction

  // Mostly realistic rates, some full-width noise.
  function automatic timing_req_t random_req();
    int unsigned osc, nr, dr, sel;
    sel = $urandom_range(9);
    if (sel < 7) begin
      osc = $urandom_range(80000000, 1000000);
      nr = $urandom_range(1000000, 10000);
      dr = ($urandom_range(3) == 0) ? 0 : $urandom_range(8000000, 100000);
    end else begin
      osc = $urandom;
      nr = $urandom;
      dr = ($urandom_range(1) == 0) ? 0 : $urandom;
    end
    return make_req(osc, nr, dr);
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || s_axis_tvalid_i || expected_timing.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i = '0;
    m_axis_tready_i = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed cases: common setups, zero divisors, prescaler limits, quanta limits.
    pending_reqs.push_back(make_req(40000000, 500000, 2000000));
    pending_reqs.push_back(make_req(40000000, 1000000, 0));
    pending_reqs.push_back(make_req(80000000, 500000, 8000000));
    pending_reqs.push_back(make_req(20000000, 250000, 0));
    pending_reqs.push_back(make_req(40000000, 0, 2000000));
    pending_reqs.push_back(make_req(0, 500000, 0));
    pending_reqs.push_back(make_req(0, 0, 0));
    pending_reqs.push_back(make_req(1000, 1000000, 0));
    pending_reqs.push_back(make_req(80000000, 1, 0));
    pending_reqs.push_back(make_req(80000000, 15625, 0));
    pending_reqs.push_back(make_req(80000000, 15686, 0));
    pending_reqs.push_back(make_req(8000000, 1000000, 0));
    pending_reqs.push_back(make_req(399, 10, 0));
    pending_reqs.push_back(make_req(799, 20, 0));
    pending_reqs.push_back(make_req(40000000, 500000, 8000000));
    pending_reqs.push_back(make_req(40000000, 500000, 800000));
    pending_reqs.push_back(make_req(40000000, 500000, 1));
    pending_reqs.push_back(make_req(32'h7FFFFFF, 32'hFFFFF, 32'h7FFFFF));
    pending_reqs.push_back(make_req(32'h7FFFFFF, 1, 32'h7FFFFF));
    pending_reqs.push_back(make_req(32'h7FFFFFF, 32'hFFFFF, 0));
    wait_drained();

    // Long receiver hold-off while the sender keeps offering.
    send_idle_pct = 0;
    hold_off_cycles = 200;
    repeat (60) pending_reqs.push_back(random_req());
    wait_drained();

    send_idle_pct = 26;
    recv_idle_pct = 85;
    repeat (160) pending_reqs.push_back(random_req());
    wait_drained();
    send_pause = 1;
    repeat (40) @(posedge clk_i);
    send_pause = 0;

    send_idle_pct = 85;
    recv_idle_pct = 26;
    repeat (160) pending_reqs.push_back(random_req());
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (170) pending_reqs.push_back(random_req());
    wait_drained();

    repeat (PipeLatency + 10) @(posedge clk_i);
    if (error_count == 0 && expected_timing.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bcc_pkg.sv
rtl/core/bcc_cell.sv
rtl/core/can_fd_bit_timing_calc_top.sv
test/testbench.sv
